>>> rtl/uss_pkg.sv
// shared types, constants and byte classification for the utf-8 sanitizer
package uss_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 4;
    localparam int HELD_DEPTH  = 3;

    localparam logic [7:0] C_REPL_RESET = 8'h3F;

    localparam logic [2:0] LEN_INVALID = 3'd0;
    localparam logic [2:0] LEN_ONE     = 3'd1;

    // one work packet from front to back: up to four result bytes
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0]      repl;
        logic [2:0]                  cnt;
        logic                        last;
    } t_cmd;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if ((c & 8'h80) == 8'h00) begin
            len = 3'd1;
        end else if ((c & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end else begin
            len = LEN_INVALID;
        end
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] c);
        return (c & 8'hC0) == 8'h80;
    endfunction

endpackage

>>> rtl/uss_front.sv
// front end: accepts bytes, tracks the open sequence and builds result packets
module uss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_q_full,
    output logic          o_push,
    output uss_pkg::t_cmd o_cmd
);

    logic [uss_pkg::HELD_DEPTH-1:0][7:0] r_held;
    logic [uss_pkg::HELD_DEPTH-1:0][7:0] n_held;
    logic [1:0]                          r_held_cnt;
    logic [1:0]                          n_held_cnt;
    logic [2:0]                          r_exp_len;
    logic [2:0]                          n_exp_len;
    uss_pkg::t_cmd                       cmd;
    logic                                accept;
    logic [2:0]                          len;
    logic [2:0]                          k_ext;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign len     = uss_pkg::lead_length(i_in_byte);
    assign k_ext   = {1'b0, r_held_cnt};

    always_comb begin
        cmd        = '0;
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_exp_len  = r_exp_len;
        if (r_held_cnt != 2'd0 && uss_pkg::is_cont(i_in_byte)) begin
            if (k_ext + 3'd1 >= r_exp_len || r_held_cnt == 2'd3) begin
                // sequence complete
                for (int i = 0; i < uss_pkg::HELD_DEPTH; i++) begin
                    if (2'(i) < r_held_cnt) begin
                        cmd.bytes[i] = r_held[i];
                    end
                end
                cmd.bytes[r_held_cnt] = i_in_byte;
                cmd.cnt               = k_ext + 3'd1;
                n_held_cnt            = 2'd0;
                n_exp_len             = 3'd0;
            end else begin
                n_held[r_held_cnt] = i_in_byte;
                n_held_cnt         = r_held_cnt + 2'd1;
                if (i_in_last) begin
                    for (int i = 0; i < uss_pkg::MAX_RESULTS; i++) begin
                        if (3'(i) < k_ext + 3'd1) begin
                            cmd.repl[i] = 1'b1;
                        end
                    end
                    cmd.cnt    = k_ext + 3'd1;
                    n_held_cnt = 2'd0;
                    n_exp_len  = 3'd0;
                end
            end
        end else begin
            // flush any broken sequence, then treat the byte as a fresh lead
            for (int i = 0; i < uss_pkg::HELD_DEPTH; i++) begin
                if (2'(i) < r_held_cnt) begin
                    cmd.repl[i] = 1'b1;
                end
            end
            cmd.cnt = k_ext;
            case (len)
                uss_pkg::LEN_ONE: begin
                    cmd.bytes[r_held_cnt] = i_in_byte;
                    cmd.cnt               = k_ext + 3'd1;
                    n_held_cnt            = 2'd0;
                    n_exp_len             = 3'd0;
                end
                uss_pkg::LEN_INVALID: begin
                    cmd.repl[r_held_cnt] = 1'b1;
                    cmd.cnt              = k_ext + 3'd1;
                    n_held_cnt           = 2'd0;
                    n_exp_len            = 3'd0;
                end
                default: begin
                    n_held[0]  = i_in_byte;
                    n_held_cnt = 2'd1;
                    n_exp_len  = len;
                    if (i_in_last) begin
                        cmd.repl[r_held_cnt] = 1'b1;
                        cmd.cnt              = k_ext + 3'd1;
                        n_held_cnt           = 2'd0;
                        n_exp_len            = 3'd0;
                    end
                end
            endcase
        end
        cmd.last = i_in_last;
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_exp_len  <= 3'd0;
        end else if (accept) begin
            r_held_cnt <= n_held_cnt;
            r_exp_len  <= n_exp_len;
        end
    end

`ifndef SYNTH
    a_held_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != 2'd0) |-> (r_exp_len > k_ext))
        else $error("held count reached expected length");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |-> (o_push && n_held_cnt == 2'd0))
        else $error("last byte left a sequence open or gave no result");
`endif

endmodule

>>> rtl/uss_queue.sv
// two-entry packet queue between front and back
module uss_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uss_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output uss_pkg::t_cmd o_data
);

    uss_pkg::t_cmd                r_mem [uss_pkg::QUEUE_DEPTH];
    logic [uss_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [uss_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [uss_pkg::QUEUE_CW-1:0] r_count;
    logic [uss_pkg::QUEUE_CW-1:0] n_count;

    assign o_full  = (r_count == uss_pkg::QUEUE_CW'(uss_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + uss_pkg::QUEUE_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - uss_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + uss_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + uss_pkg::QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

>>> rtl/uss_back.sv
// back end: plays out each packet one result byte per transfer
module uss_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_q_valid,
    input  uss_pkg::t_cmd i_q_data,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_was_replaced,
    output logic          o_out_last
);

    uss_pkg::t_cmd r_cmd;
    logic          r_busy;
    logic          n_busy;
    logic [1:0]    r_idx;
    logic [1:0]    n_idx;
    logic [7:0]    r_repl;
    logic          final_res;
    logic          done;

    assign final_res = ({1'b0, r_idx} + 3'd1 == r_cmd.cnt);
    assign done      = r_busy && !i_stall && final_res;
    assign o_pop     = i_q_valid && (!r_busy || done);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (r_busy && !i_stall) begin
            n_idx = r_idx + 2'd1;
        end
    end

    assign o_valid        = r_busy;
    assign o_was_replaced = r_cmd.repl[r_idx];
    assign o_out_byte     = r_cmd.repl[r_idx] ? r_repl : r_cmd.bytes[r_idx];
    assign o_out_last     = r_cmd.last && final_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_repl <= uss_pkg::C_REPL_RESET;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (i_cfg_we) begin
                r_repl <= i_cfg_data;
            end
        end
    end

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < r_cmd.cnt))
        else $error("result index beyond packet count");
`endif

endmodule

>>> rtl/utf8_sequence_sanitizer.sv
// top level of the utf-8 sequence sanitizer
// Takes one byte per cycle when not stalled and passes well-formed utf-8 sequences through,
// writing the replacement byte (reset 0x3F) for each byte of a bad or cut-off sequence.
// Bytes of an open multi-byte sequence are held until it completes or breaks, so one input
// byte gives zero to four results; results leave one per cycle from the output stage when
// not stalled, and a two-entry packet queue lets the input side keep taking bytes while
// results are drained. Sustained rate is one byte per cycle while results average one per
// byte; a byte's n results hold the output stage until all have left. Packets pass through
// the queue and output registers. The replacement byte may be written only while idle.
module utf8_sequence_sanitizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_was_replaced,
    output logic       o_out_last,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    uss_pkg::t_cmd front_cmd;
    uss_pkg::t_cmd q_data;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    uss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    uss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    uss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_data       (q_data),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_was_replaced (o_was_replaced),
        .o_out_last     (o_out_last)
    );

endmodule

>>> verif/utf8_sequence_sanitizer_tb.sv
// self-checking testbench for the utf-8 sequence sanitizer
module utf8_sequence_sanitizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PRESSURE_HOLD = 60;
    localparam int unsigned RAW_MIN       = 1;

    typedef struct packed {
        logic [7:0] data;
        logic       replaced;
        logic       last;
    } t_out_rec;

    class t_text_scoreboard;
        logic [7:0]  repl_byte = uss_pkg::C_REPL_RESET;
        logic [7:0]  held [3];
        int unsigned held_cnt = 0;
        int unsigned seq_len = 0;
        int unsigned errors = 0;
        t_out_rec    expected_text[$];
        t_out_rec    step_out[$];

        function int unsigned seq_length(logic [7:0] c);
            casez (c)
                8'b0???????: return 1;
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 0;
            endcase
        endfunction

        function void put(logic [7:0] d, logic r);
            t_out_rec rec;
            rec.data = d;
            rec.replaced = r;
            rec.last = 1'b0;
            step_out.push_back(rec);
        endfunction

        function void flush_held();
            int unsigned i;
            for (i = 0; i < held_cnt; i++) put(repl_byte, 1'b1);
            held_cnt = 0;
            seq_len = 0;
        endfunction

        function void start_char(logic [7:0] c);
            int unsigned n;
            n = seq_length(c);
            if (n == 1) begin
                put(c, 1'b0);
            end else if (n == 0) begin
                put(repl_byte, 1'b1);
            end else begin
                held[0] = c;
                held_cnt = 1;
                seq_len = n;
            end
        endfunction

        function void note_in_byte(logic [7:0] c, logic last);
            int unsigned i;
            t_out_rec rec;
            step_out.delete();
            if (held_cnt == 0) begin
                start_char(c);
            end else if (c[7:6] == 2'b10) begin
                if (held_cnt + 1 >= seq_len) begin
                    for (i = 0; i < held_cnt; i++) put(held[i], 1'b0);
                    put(c, 1'b0);
                    held_cnt = 0;
                    seq_len = 0;
                end else begin
                    held[held_cnt] = c;
                    held_cnt++;
                end
            end else begin
                flush_held();
                start_char(c);
            end
            if (last) begin
                if (held_cnt != 0) flush_held();
                if (step_out.size() > 0) begin
                    rec = step_out.pop_back();
                    rec.last = 1'b1;
                    step_out.push_back(rec);
                end
            end
            foreach (step_out[i]) expected_text.push_back(step_out[i]);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_out_byte(logic [7:0] d, logic r, logic l);
            t_out_rec want;
            if (expected_text.size() == 0) begin
                report($sformatf("unexpected byte %02h repl %0b last %0b", d, r, l));
                return;
            end
            want = expected_text.pop_front();
            if (want.data !== d || want.replaced !== r || want.last !== l)
                report($sformatf("expected %02h repl %0b last %0b, got %02h repl %0b last %0b",
                                 want.data, want.replaced, want.last, d, r, l));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_stall = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_was_replaced;
    logic       o_out_last;

    t_text_scoreboard sb;
    logic [7:0]       text_q[$];
    int unsigned      items_sent = 0;
    int unsigned      tx_idle_pct = 0;
    int unsigned      rx_idle_pct = 0;
    logic             pressure_on = 1'b0;
    int unsigned      hold_count = 0;

    utf8_sequence_sanitizer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_was_replaced (o_was_replaced),
        .o_out_last     (o_out_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // random stalls, with a long one-shot hold once pressure is switched on
    always @(posedge i_clk) begin
        if (pressure_on && hold_count < PRESSURE_HOLD) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_stall <= ($urandom_range(1, 100) <= rx_idle_pct);
        end
    end

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && i_valid === 1'b1 && o_stall === 1'b0)
            sb.note_in_byte(i_in_byte, i_in_last);
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_out_byte(o_out_byte, o_was_replaced, o_out_last);
    end

    function automatic logic [7:0] lead_of(int unsigned n);
        case (n)
            1:       return 8'($urandom_range(RAW_MIN, 127));
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic void add_char();
        int unsigned pick, n, k;
        pick = $urandom_range(0, 99);
        n = $urandom_range(1, 4);
        if (pick < 70) begin
            text_q.push_back(lead_of(n));
            for (k = 1; k < n; k++) text_q.push_back(cont_byte());
        end else if (pick < 78) begin
            text_q.push_back(cont_byte());
        end else if (pick < 84) begin
            text_q.push_back(8'($urandom_range(248, 255)));
        end else if (pick < 94) begin
            n = $urandom_range(2, 4);
            text_q.push_back(lead_of(n));
            for (k = 2; k < n; k++)
                if ($urandom_range(0, 1) == 1) text_q.push_back(cont_byte());
        end else begin
            text_q.push_back(8'($urandom_range(RAW_MIN, 255)));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(1, 100) <= tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic send_text(input logic end_string);
        int unsigned i;
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], end_string && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.expected_text.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_repl(input logic [7:0] v);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.repl_byte = v;
    endtask

    task automatic random_phase(input int unsigned n_items, input logic leave_open);
        int unsigned stop_at, chars, j;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            chars = $urandom_range(1, 10);
            for (j = 0; j < chars; j++) add_char();
            send_text(1'b1);
        end
        if (leave_open) begin
            text_q.push_back(lead_of($urandom_range(2, 4)));
            if ($urandom_range(0, 1) == 1) text_q.push_back(cont_byte());
            send_text(1'b0);
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ascii extremes and a zero byte at the end of a string
        text_q = '{8'h41, 8'h7F, 8'h01, 8'h00};
        send_text(1'b1);
        // two, three and four byte characters
        text_q = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text(1'b1);
        // stray continuations, bad leads, a broken three byte sequence
        text_q = '{8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hE2, 8'h82, 8'h41};
        send_text(1'b1);
        // three held bytes broken by a lead, then a cut-off sequence
        text_q = '{8'hF4, 8'h80, 8'h80, 8'hC3, 8'hA9, 8'hE1, 8'h80};
        send_text(1'b1);
        // replacement changed while a sequence is open
        text_q = '{8'hF0, 8'h90};
        send_text(1'b0);
        write_repl(8'hFF);
        text_q = '{8'h41};
        send_text(1'b1);

        write_repl(8'h00);
        tx_idle_pct = 22;
        rx_idle_pct <= 77;
        random_phase(60, 1'b1);

        write_repl(8'($urandom_range(1, 254)));
        tx_idle_pct = 77;
        rx_idle_pct <= 22;
        random_phase(60, 1'b1);

        write_repl(8'($urandom_range(0, 255)));
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        pressure_on <= 1'b1;
        random_phase(65, 1'b0);

        i_valid <= 1'b0;
        wait_drained();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/uss_pkg.sv
rtl/uss_front.sv
rtl/uss_queue.sv
rtl/uss_back.sv
rtl/utf8_sequence_sanitizer.sv
verif/utf8_sequence_sanitizer_tb.sv
